@@ sv/fbfla_pkg.sv @@
// Shared constants and types for the fixed block free list allocator.
package fbfla_pkg;

  localparam int BLOCKS = 256;
  localparam int IDX_W = $clog2(BLOCKS);
  localparam int LINK_W = IDX_W + 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BLOCKS);

  localparam int CNT_W = 9;
  localparam int STRIDE_W = 13;
  localparam int CFG_DATA_W = 13;
  localparam int OFFSET_W = 20;
  localparam int OUT_IDX_W = 8;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    CFG_BLOCKS_IN_USE = 1'b0,
    CFG_BLOCK_STRIDE  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_INIT  = 3'b010,
    S_ALLOC = 3'b100
  } state_t;

endpackage

@@ sv/fixed_block_free_list_allocator_unit.sv @@
// Fixed-size block pool allocator: free list kept in a link memory, one head register.
//
// The pool is a singly linked free list: a 256-entry link memory holds, for every free
// block, the index of the next free block, and a head register points at the first one.
// The pool is empty after reset until an init or a free transaction is taken. The link
// memory is read through a registered port. Free, the unused opcode, allocate on an
// empty pool and init with a zero count give their result as they are taken; allocate
// first reads the link of the head block, then pops it and computes index times stride
// on the single 8x13 multiplier; init chains min(blocks_in_use, 256) blocks, one link
// write per cycle, in the init state before its result is given. One transaction is
// worked on at a time; a new one is taken only when the output register is empty or
// its result is taken at the same edge. Configuration is written through cfg_write /
// cfg_index / cfg_data and is applied at once.
module fixed_block_free_list_allocator_unit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     opcode,
  input  logic [7:0]                     block_index,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           status,
  output logic [7:0]                     given_index,
  output logic [19:0]                    byte_offset
);
  import fbfla_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]    blocks_in_use;
  logic [STRIDE_W-1:0] block_stride;

  // control state
  state_t              state;
  logic [LINK_W-1:0]   head;
  logic [IDX_W-1:0]    ctr;
  logic [IDX_W-1:0]    last;

  // link memory
  logic [LINK_W-1:0]   link_mem [BLOCKS];
  logic [LINK_W-1:0]   rd_data;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [LINK_W-1:0]   mem_wdata;

  logic                in_acc;
  logic                head_null;
  logic                free_ok;
  logic [IDX_W-1:0]    free_idx;
  logic [31:0]         init_count;
  logic [LINK_W-1:0]   nxt_link;
  logic [IDX_W+STRIDE_W-1:0] product;

  // take a transaction only when idle and the result slot is free this edge
  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign head_null = 32'(head) >= BLOCKS;
  assign free_ok   = 32'(block_index) < BLOCKS;
  assign free_idx  = IDX_W'(block_index);
  // saturate the chain length at the pool size
  assign init_count = (32'(blocks_in_use) > BLOCKS) ? BLOCKS : 32'(blocks_in_use);
  // a stale link past the pool reads as the null mark
  assign nxt_link  = (32'(rd_data) >= BLOCKS) ? NULL_LINK : rd_data;
  assign product   = head[IDX_W-1:0] * block_stride;

  // link memory write: init sweep or free push
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ctr;
    mem_wdata = NULL_LINK;
    if (state == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = ctr;
      mem_wdata = (ctr == last) ? NULL_LINK : LINK_W'(ctr) + LINK_W'(1);
    end else if (in_acc && opcode == OP_FREE && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = free_idx;
      mem_wdata = head_null ? NULL_LINK : head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= link_mem[head[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= CNT_W'(256);
      block_stride  <= STRIDE_W'(8);
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[CNT_W-1:0];
        CFG_BLOCK_STRIDE:  block_stride  <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NULL_LINK;
      out_valid <= 1'b0;
      ctr       <= '0;
      last      <= '0;
    end else begin
      // drop the result once taken
      if (out_valid && !out_stall && !in_acc) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            status      <= 1'b0;
            given_index <= '0;
            byte_offset <= '0;
            case (op_e'(opcode))
              OP_INIT: begin
                if (init_count == 32'd0) begin
                  head      <= NULL_LINK;
                  out_valid <= 1'b1;
                end else begin
                  ctr       <= '0;
                  last      <= IDX_W'(init_count - 32'd1);
                  out_valid <= 1'b0;
                  state     <= S_INIT;
                end
              end
              OP_ALLOC: begin
                if (head_null) begin
                  head      <= NULL_LINK;
                  status    <= 1'b1;
                  out_valid <= 1'b1;
                end else begin
                  // wait in S_ALLOC for the registered read of the head block's link
                  out_valid <= 1'b0;
                  state     <= S_ALLOC;
                end
              end
              OP_FREE: begin
                if (free_ok) begin
                  head <= LINK_W'(free_idx);
                end
                out_valid <= 1'b1;
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_INIT: begin
          // advance the sweep; close the chain at the last block
          if (ctr == last) begin
            head      <= '0;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            ctr <= ctr + IDX_W'(1);
          end
        end
        S_ALLOC: begin
          // pop the head block
          given_index <= OUT_IDX_W'(head[IDX_W-1:0]);
          byte_offset <= OFFSET_W'(product);
          head        <= nxt_link;
          out_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the result slot stays empty while a transaction is in flight
  a_slot_empty_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("result pending while a transaction is in flight");

  // the head never points past the null mark
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(head) <= BLOCKS)
    else $error("head out of range");

  // an allocate from a non-empty pool yields a successful result after its S_ALLOC step
  a_alloc_latency: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_ALLOC && !head_null) |-> ##2 (out_valid && !status))
    else $error("allocate result missing");

  // a free of a block in range makes it the new head
  a_free_head: assert property (@(posedge clk) disable iff (rst)
    (in_acc && opcode == OP_FREE && free_ok) |=> (head == LINK_W'($past(free_idx))))
    else $error("freed block not at head");

endmodule
